// ----- rtl/fdpc_pkg.sv -----
`default_nettype none

package fdpc_pkg;

	// Fixed field widths of the block.
	localparam int XTAL_W  = 32;
	localparam int MULT_W  = 7;
	localparam int MASK_W  = 3;
	localparam int CH_W    = 2;
	localparam int FREQ_W  = 28;
	localparam int PROD_W  = 39;
	localparam int A_W     = 11;
	localparam int P1_W    = 18;
	localparam int P2_W    = 20;
	localparam int P3_W    = 20;
	localparam int CNT_W   = 6;
	localparam int FRAC_SH = 7;

	localparam int NUM_CHANNELS = 3;

	localparam logic [CNT_W-1:0] DIV_STEPS = CNT_W'(PROD_W);
	localparam logic [P1_W-1:0]  P1_OFFSET = P1_W'(512);

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_XTAL_FREQ   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PLL_A_MULT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PLL_B_MULT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_MASK = 2'd3;

	// Datapath operations.
	typedef enum logic [3:0] {
		OP_NOP,
		OP_LOAD,
		OP_PROD,
		OP_DIV,
		OP_SAVE_A,
		OP_MUL_L,
		OP_MUL_R,
		OP_WALK_CMP,
		OP_WALK_END,
		OP_FRAC_LOAD,
		OP_EMIT,
		OP_EMIT_ZERO
	} op_t;

	// Conditions a step waits on before it executes.
	typedef enum logic [1:0] {
		WT_NONE,
		WT_IN,
		WT_OUT
	} wait_t;

	// Branch conditions, evaluated when the step executes.
	typedef enum logic [2:0] {
		BR_NONE,
		BR_ALWAYS,
		BR_FZERO,
		BR_REMZ,
		BR_MORE,
		BR_CONT
	} br_t;

	localparam int PC_W = 4;
	typedef logic [PC_W-1:0] pc_t;

	localparam pc_t ST_LOAD      = 4'd0;
	localparam pc_t ST_PROD      = 4'd1;
	localparam pc_t ST_DIV_A     = 4'd2;
	localparam pc_t ST_SAVE_A    = 4'd3;
	localparam pc_t ST_MUL_L     = 4'd4;
	localparam pc_t ST_MUL_R     = 4'd5;
	localparam pc_t ST_WALK_CMP  = 4'd6;
	localparam pc_t ST_WALK_END  = 4'd7;
	localparam pc_t ST_FRAC_LOAD = 4'd8;
	localparam pc_t ST_DIV_F     = 4'd9;
	localparam pc_t ST_EMIT      = 4'd10;
	localparam pc_t ST_EMIT_ZERO = 4'd11;

	typedef struct packed {
		op_t   op;
		wait_t wt;
		br_t   br;
		pc_t   target;
	} ucode_t;

	// Status flags from the datapath to the sequencer.
	typedef struct packed {
		logic freq_zero;
		logic rem_zero;
		logic cnt_more;
		logic walk_cont;
		logic out_free;
	} dp_stat_t;

	// The microprogram.
	function automatic ucode_t ucode_rom(input pc_t pc);
		ucode_t w;
		w = '{op: OP_NOP, wt: WT_NONE, br: BR_ALWAYS, target: ST_LOAD};
		case (pc)
			ST_LOAD:      w = '{op: OP_LOAD,      wt: WT_IN,   br: BR_NONE,   target: ST_LOAD};
			ST_PROD:      w = '{op: OP_PROD,      wt: WT_NONE, br: BR_FZERO,  target: ST_EMIT_ZERO};
			ST_DIV_A:     w = '{op: OP_DIV,       wt: WT_NONE, br: BR_MORE,   target: ST_DIV_A};
			ST_SAVE_A:    w = '{op: OP_SAVE_A,    wt: WT_NONE, br: BR_REMZ,   target: ST_FRAC_LOAD};
			ST_MUL_L:     w = '{op: OP_MUL_L,     wt: WT_NONE, br: BR_NONE,   target: ST_LOAD};
			ST_MUL_R:     w = '{op: OP_MUL_R,     wt: WT_NONE, br: BR_NONE,   target: ST_LOAD};
			ST_WALK_CMP:  w = '{op: OP_WALK_CMP,  wt: WT_NONE, br: BR_CONT,   target: ST_MUL_L};
			ST_WALK_END:  w = '{op: OP_WALK_END,  wt: WT_NONE, br: BR_NONE,   target: ST_LOAD};
			ST_FRAC_LOAD: w = '{op: OP_FRAC_LOAD, wt: WT_NONE, br: BR_NONE,   target: ST_LOAD};
			ST_DIV_F:     w = '{op: OP_DIV,       wt: WT_NONE, br: BR_MORE,   target: ST_DIV_F};
			ST_EMIT:      w = '{op: OP_EMIT,      wt: WT_OUT,  br: BR_ALWAYS, target: ST_LOAD};
			ST_EMIT_ZERO: w = '{op: OP_EMIT_ZERO, wt: WT_OUT,  br: BR_ALWAYS, target: ST_LOAD};
			default:      w = '{op: OP_NOP,       wt: WT_NONE, br: BR_ALWAYS, target: ST_LOAD};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/fdpc_seq.sv -----
`default_nettype none

module fdpc_seq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire fdpc_pkg::dp_stat_t stat,
	output fdpc_pkg::op_t           op,
	output logic                    in_ready
);

	fdpc_pkg::pc_t    pc_q;
	fdpc_pkg::pc_t    pc_d;
	fdpc_pkg::ucode_t cw;
	logic             wait_ok;
	logic             br_take;

	always_comb begin
		cw = fdpc_pkg::ucode_rom(pc_q);

		case (cw.wt)
			fdpc_pkg::WT_NONE: wait_ok = 1'b1;
			fdpc_pkg::WT_IN:   wait_ok = in_valid;
			fdpc_pkg::WT_OUT:  wait_ok = stat.out_free;
			default:           wait_ok = 1'b0;
		endcase

		case (cw.br)
			fdpc_pkg::BR_NONE:   br_take = 1'b0;
			fdpc_pkg::BR_ALWAYS: br_take = 1'b1;
			fdpc_pkg::BR_FZERO:  br_take = stat.freq_zero;
			fdpc_pkg::BR_REMZ:   br_take = stat.rem_zero;
			fdpc_pkg::BR_MORE:   br_take = stat.cnt_more;
			fdpc_pkg::BR_CONT:   br_take = stat.walk_cont;
			default:             br_take = 1'b0;
		endcase

		if (!wait_ok) begin
			pc_d = pc_q;
		end else if (br_take) begin
			pc_d = cw.target;
		end else begin
			pc_d = pc_q + fdpc_pkg::PC_W'(1);
		end

		op       = wait_ok ? cw.op : fdpc_pkg::OP_NOP;
		in_ready = (cw.wt == fdpc_pkg::WT_IN);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= fdpc_pkg::ST_LOAD;
		end else begin
			pc_q <= pc_d;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/fdpc_dp.sv -----
`default_nettype none

module fdpc_dp #(
	parameter int MAX_DENOM = 1048575
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire fdpc_pkg::op_t                 op,
	input  wire logic [fdpc_pkg::XTAL_W-1:0]   xtal_freq,
	input  wire logic [fdpc_pkg::MULT_W-1:0]   pll_a_mult,
	input  wire logic [fdpc_pkg::MULT_W-1:0]   pll_b_mult,
	input  wire logic [fdpc_pkg::MASK_W-1:0]   pll_source_mask,
	input  wire logic [fdpc_pkg::CH_W-1:0]     channel,
	input  wire logic [fdpc_pkg::FREQ_W-1:0]   target_freq,
	input  wire logic                          out_ready,
	output fdpc_pkg::dp_stat_t                 stat,
	output logic                               out_valid,
	output logic [fdpc_pkg::CH_W-1:0]          out_channel,
	output logic                               int_mode,
	output logic [fdpc_pkg::P1_W-1:0]          p1_value,
	output logic [fdpc_pkg::P2_W-1:0]          p2_value,
	output logic [fdpc_pkg::P3_W-1:0]          p3_value,
	output logic [63:0]                        packed_bytes,
	output logic                               status
);

	// Walk registers are one bit wider than the bound, since a mediant
	// denominator can reach twice the bound before the walk stops.
	localparam int CW  = $clog2(MAX_DENOM + 1);
	localparam int DW  = CW + 1;
	localparam int MW  = (DW > fdpc_pkg::MULT_W) ? DW : fdpc_pkg::MULT_W;
	localparam int MPW = fdpc_pkg::XTAL_W + MW;
	localparam int LW  = fdpc_pkg::FREQ_W + DW;
	localparam logic [DW-1:0] LIM = DW'(MAX_DENOM);

	localparam int PW = fdpc_pkg::PROD_W;
	localparam int FW = fdpc_pkg::FREQ_W;

	logic [fdpc_pkg::CH_W-1:0]   ch_q;
	logic [FW-1:0]               freq_q;
	logic [fdpc_pkg::MULT_W-1:0] mult_q;
	logic [PW-1:0]               div_n_q;
	logic [FW-1:0]               div_d_q;
	logic [FW-1:0]               div_r_q;
	logic [fdpc_pkg::CNT_W-1:0]  cnt_q;
	logic [fdpc_pkg::A_W-1:0]    a_q;
	logic [FW-1:0]               rem_q;
	logic [DW-1:0]               p_q, q_q, r_q, s_q;
	logic [DW-1:0]               b_q, c_q;
	logic [LW-1:0]               lhs_q, rhs_q;
	logic                        eq_q;
	logic                        im_q;
	logic                        out_valid_q;

	logic [DW-1:0]               mn, md;
	logic                        cross_eq;
	logic [FW:0]                 div_trial;
	logic                        div_ge;
	logic [fdpc_pkg::XTAL_W-1:0] mul_a;
	logic [MW-1:0]               mul_b;
	logic [MPW-1:0]              mul_res;
	logic                        sel_b;
	logic [fdpc_pkg::P1_W-1:0]   p1_calc;
	logic [fdpc_pkg::P2_W-1:0]   p2_calc;
	logic [fdpc_pkg::P3_W-1:0]   c_out;

	assign mn       = p_q + r_q;
	assign md       = q_q + s_q;
	assign cross_eq = (lhs_q == rhs_q);

	// One restoring division step: shift in the next dividend bit.
	assign div_trial = {div_r_q, div_n_q[PW-1]};
	assign div_ge    = (div_trial >= {1'b0, div_d_q});

	// The one multiplier, shared by the product and both cross products.
	always_comb begin
		case (op)
			fdpc_pkg::OP_MUL_L: begin
				mul_a = fdpc_pkg::XTAL_W'(rem_q);
				mul_b = MW'(md);
			end
			fdpc_pkg::OP_MUL_R: begin
				mul_a = fdpc_pkg::XTAL_W'(freq_q);
				mul_b = MW'(mn);
			end
			default: begin
				mul_a = xtal_freq;
				mul_b = MW'(mult_q);
			end
		endcase
	end

	assign mul_res = MPW'(mul_a) * MPW'(mul_b);

	assign sel_b = (32'(channel) < fdpc_pkg::NUM_CHANNELS) && (channel < 2'd3)
		&& pll_source_mask[channel];

	// The fraction quotient reaches 128 when the walk ends on one whole.
	assign p1_calc = {a_q, 7'd0} + fdpc_pkg::P1_W'(div_n_q[fdpc_pkg::FRAC_SH:0])
		- fdpc_pkg::P1_OFFSET;
	assign p2_calc = fdpc_pkg::P2_W'(div_r_q);
	assign c_out   = fdpc_pkg::P3_W'(c_q);

	assign stat.freq_zero = (freq_q == '0);
	assign stat.rem_zero  = (div_r_q == '0);
	assign stat.cnt_more  = (cnt_q != fdpc_pkg::CNT_W'(1));
	assign stat.walk_cont = !cross_eq && (md <= LIM);
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op == fdpc_pkg::OP_EMIT || op == fdpc_pkg::OP_EMIT_ZERO) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			fdpc_pkg::OP_LOAD: begin
				ch_q   <= channel;
				freq_q <= target_freq;
				mult_q <= sel_b ? pll_b_mult : pll_a_mult;
			end
			fdpc_pkg::OP_PROD: begin
				div_n_q <= mul_res[PW-1:0];
				div_d_q <= freq_q;
				div_r_q <= '0;
				cnt_q   <= fdpc_pkg::DIV_STEPS;
			end
			fdpc_pkg::OP_DIV: begin
				div_r_q <= div_ge ? FW'(div_trial - {1'b0, div_d_q}) : div_trial[FW-1:0];
				div_n_q <= {div_n_q[PW-2:0], div_ge};
				cnt_q   <= cnt_q - fdpc_pkg::CNT_W'(1);
			end
			fdpc_pkg::OP_SAVE_A: begin
				a_q   <= div_n_q[fdpc_pkg::A_W-1:0];
				rem_q <= div_r_q;
				im_q  <= (div_r_q == '0);
				eq_q  <= 1'b0;
				p_q   <= '0;
				q_q   <= DW'(1);
				r_q   <= DW'(1);
				s_q   <= DW'(1);
				b_q   <= '0;
				c_q   <= DW'(1);
			end
			fdpc_pkg::OP_MUL_L: begin
				lhs_q <= mul_res[LW-1:0];
			end
			fdpc_pkg::OP_MUL_R: begin
				rhs_q <= mul_res[LW-1:0];
			end
			fdpc_pkg::OP_WALK_CMP: begin
				if (cross_eq) begin
					eq_q <= 1'b1;
					if (md <= LIM) begin
						b_q <= mn;
						c_q <= md;
					end else if (s_q > q_q) begin
						b_q <= r_q;
						c_q <= s_q;
					end else begin
						b_q <= p_q;
						c_q <= q_q;
					end
				end else if (lhs_q > rhs_q) begin
					p_q <= mn;
					q_q <= md;
				end else begin
					r_q <= mn;
					s_q <= md;
				end
			end
			fdpc_pkg::OP_WALK_END: begin
				if (!eq_q) begin
					if (q_q > LIM) begin
						b_q <= r_q;
						c_q <= s_q;
					end else begin
						b_q <= p_q;
						c_q <= q_q;
					end
				end
			end
			fdpc_pkg::OP_FRAC_LOAD: begin
				div_n_q <= PW'({b_q, 7'd0});
				div_d_q <= FW'(c_q);
				div_r_q <= '0;
				cnt_q   <= fdpc_pkg::DIV_STEPS;
			end
			fdpc_pkg::OP_EMIT: begin
				out_channel  <= ch_q;
				int_mode     <= im_q;
				p1_value     <= p1_calc;
				p2_value     <= p2_calc;
				p3_value     <= c_out;
				packed_bytes <= {c_out[15:8], c_out[7:0], 6'd0, p1_calc[17:16],
					p1_calc[15:8], p1_calc[7:0], c_out[19:16], p2_calc[19:16],
					p2_calc[15:8], p2_calc[7:0]};
				status       <= 1'b0;
			end
			fdpc_pkg::OP_EMIT_ZERO: begin
				out_channel  <= '0;
				int_mode     <= 1'b0;
				p1_value     <= '0;
				p2_value     <= '0;
				p3_value     <= '0;
				packed_bytes <= '0;
				status       <= 1'b1;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- rtl/fractional_divider_parameter_calc.sv -----
// Fractional output-divider parameter calculator. Each transfer on the input
// channel gives a channel and a target frequency; the block picks PLL A or B
// for that channel from the source mask, divides xtal_freq * mult by the
// target frequency, approximates the fraction by a Stern-Brocot walk bounded
// by MAX_DENOM, and delivers one result transfer with P1, P2, P3, the
// integer-mode flag and the eight packed register bytes. Items are handled
// one at a time. An item with a fractional divider takes longer the more
// mediant steps W its walk has; an exact integer divider skips the walk.
// W can approach MAX_DENOM for fractions close to zero or one. Each walk
// step sends both cross products through one shared multiplier before the
// compare, and each of the two divisions runs one quotient bit per cycle
// over the 39 bits of its dividend. A zero target frequency skips both
// divisions and is reported with status set. The next input transfer is
// taken as soon as the result register has been loaded, while that result
// still waits for its transfer.

`default_nettype none

module fractional_divider_parameter_calc #(
	parameter int MAX_DENOM = 1048575
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [fdpc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [fdpc_pkg::XTAL_W-1:0]      cfg_wdata,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [fdpc_pkg::CH_W-1:0]        channel,
	input  wire logic [fdpc_pkg::FREQ_W-1:0]      target_freq,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [fdpc_pkg::CH_W-1:0]             out_channel,
	output logic                                  int_mode,
	output logic [fdpc_pkg::P1_W-1:0]             p1_value,
	output logic [fdpc_pkg::P2_W-1:0]             p2_value,
	output logic [fdpc_pkg::P3_W-1:0]             p3_value,
	output logic [63:0]                           packed_bytes,
	output logic                                  status
);

	// Configuration registers, to be written only while the block is idle; the block itself does not enforce this.
	logic [fdpc_pkg::XTAL_W-1:0] xtal_freq_q;
	logic [fdpc_pkg::MULT_W-1:0] pll_a_mult_q;
	logic [fdpc_pkg::MULT_W-1:0] pll_b_mult_q;
	logic [fdpc_pkg::MASK_W-1:0] pll_source_mask_q;

	fdpc_pkg::op_t      op;
	fdpc_pkg::dp_stat_t stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xtal_freq_q       <= 32'd25000000;
			pll_a_mult_q      <= 7'd36;
			pll_b_mult_q      <= 7'd36;
			pll_source_mask_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				fdpc_pkg::CFG_XTAL_FREQ:   xtal_freq_q       <= cfg_wdata;
				fdpc_pkg::CFG_PLL_A_MULT:  pll_a_mult_q      <= cfg_wdata[fdpc_pkg::MULT_W-1:0];
				fdpc_pkg::CFG_PLL_B_MULT:  pll_b_mult_q      <= cfg_wdata[fdpc_pkg::MULT_W-1:0];
				fdpc_pkg::CFG_SOURCE_MASK: pll_source_mask_q <= cfg_wdata[fdpc_pkg::MASK_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The sequencer steps through the microprogram and issues one datapath
	// operation per cycle; it stalls on the input and output handshakes.
	fdpc_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.stat     (stat),
		.op       (op),
		.in_ready (in_ready)
	);

	// The datapath holds the shared divider, the walk registers, the
	// multiplier and the result register.
	fdpc_dp #(
		.MAX_DENOM (MAX_DENOM)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.op              (op),
		.xtal_freq       (xtal_freq_q),
		.pll_a_mult      (pll_a_mult_q),
		.pll_b_mult      (pll_b_mult_q),
		.pll_source_mask (pll_source_mask_q),
		.channel         (channel),
		.target_freq     (target_freq),
		.out_ready       (out_ready),
		.stat            (stat),
		.out_valid       (out_valid),
		.out_channel     (out_channel),
		.int_mode        (int_mode),
		.p1_value        (p1_value),
		.p2_value        (p2_value),
		.p3_value        (p3_value),
		.packed_bytes    (packed_bytes),
		.status          (status)
	);

	// An accepted item keeps the block busy for at least the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
	else $error("input accepted on two consecutive cycles");

	// A zero-frequency result carries no parameters.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> p1_value == '0 && p2_value == '0 && p3_value == '0
			&& packed_bytes == '0 && !int_mode)
	else $error("zero-frequency result with non-zero fields");

	// An integer divider has no fraction: P2 is zero and P3 is one.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && int_mode |-> p2_value == '0 && p3_value == 20'd1 && !status)
	else $error("integer-mode result with a fraction");

	// A valid result never has a zero denominator.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !status |-> p3_value != '0)
	else $error("result with zero denominator");

endmodule

`default_nettype wire

// ----- tb/fractional_divider_parameter_calc_tb.sv -----
`timescale 1ns / 1ps

// Self-checking bench for the fractional divider parameter calculator.
// Every input transfer is predicted in full when it is offered, and the
// expectation is queued. A separate checking process compares each result
// transfer, field by field, with the oldest queued expectation.
module fractional_divider_parameter_calc_tb;

	import fdpc_pkg::*;

	// Denominator bound of the Stern-Brocot walk, passed to the block as well.
	localparam longint unsigned WALK_DENOM_MAX = 1048575;
	// Highest target frequency that the bench offers; the input field allows more.
	localparam logic [FREQ_W-1:0] FREQ_MAX = 28'd225000000;
	// Random items whose walk would run longer than this are drawn again, so
	// that one unlucky fraction close to zero or one cannot hold up the whole
	// run. Directed items cover the short and the bounded walks.
	localparam int unsigned WALK_CAP = 3000;
	// Cycles to let pass once the last expected result has arrived.
	localparam int SETTLE_CYCLES = 200;
	// Consecutive Fibonacci numbers. F30/F31 and F29/F31 are mediants whose
	// denominator lies beyond the bound while both parents lie within it.
	localparam longint unsigned FIB_29 = 514229;
	localparam longint unsigned FIB_30 = 832040;
	localparam longint unsigned FIB_31 = 1346269;
	localparam logic [MULT_W-1:0] MEDIANT_MULT = 7'd36;

	// One result transfer as the block should deliver it.
	typedef struct packed {
		logic [CH_W-1:0] channel;
		logic            int_mode;
		logic [P1_W-1:0] p1;
		logic [P2_W-1:0] p2;
		logic [P3_W-1:0] p3;
		logic [63:0]     reg_bytes;
		logic            status;
	} divider_params_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [XTAL_W-1:0]     cfg_wdata;
	logic                  in_valid;
	logic                  in_ready;
	logic [CH_W-1:0]       channel;
	logic [FREQ_W-1:0]     target_freq;
	logic                  out_valid;
	logic                  out_ready;
	logic [CH_W-1:0]       out_channel;
	logic                  int_mode;
	logic [P1_W-1:0]       p1_value;
	logic [P2_W-1:0]       p2_value;
	logic [P3_W-1:0]       p3_value;
	logic [63:0]           packed_bytes;
	logic                  status;

	// The bench's own copy of the configuration registers, updated as each
	// register write is driven.
	logic [XTAL_W-1:0]     xtal_reg;
	logic [MULT_W-1:0]     mult_a_reg;
	logic [MULT_W-1:0]     mult_b_reg;
	logic [MASK_W-1:0]     source_mask_reg;

	divider_params_t       expected_params[$];
	int                    mismatches = 0;
	int                    results_checked = 0;
	longint unsigned       cycle_budget = 0;
	longint unsigned       cycles_run = 0;
	// When set, neither side idles, so the block alone sets the pace of the transfers.
	bit                    steady_flow = 1'b0;

	fractional_divider_parameter_calc #(
		.MAX_DENOM(int'(WALK_DENOM_MAX))
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.channel(channel),
		.target_freq(target_freq),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_channel(out_channel),
		.int_mode(int_mode),
		.p1_value(p1_value),
		.p2_value(p2_value),
		.p3_value(p3_value),
		.packed_bytes(packed_bytes),
		.status(status)
	);

	always #1 clk = ~clk;

	// Works out the divider parameters for one item from the current register
	// copy. The divider N = xtal * mult / freq is split into a whole part and
	// an exact remainder; the remainder fraction is approximated by walking
	// the Stern-Brocot tree with exact cross products. walk_len returns the
	// number of mediant steps, which sets how long the block will take.
	function automatic divider_params_t calc_divider(input logic [CH_W-1:0] ch,
			input logic [FREQ_W-1:0] freq, output int unsigned walk_len);
		divider_params_t res;
		logic [63:0] freq64, mult, prod, whole, rem;
		logic [63:0] lo_n, lo_d, hi_n, hi_d, med_n, med_d, lhs, rhs;
		logic [63:0] num, den, q128, p1_full, p2_full;
		logic [P1_W-1:0] p1;
		logic [P2_W-1:0] p2;
		logic [P3_W-1:0] c;
		bit settled;
		res = '0;
		walk_len = 0;
		if (freq == '0) begin
			res.status = 1'b1;
			return res;
		end
		freq64 = 64'(freq);
		// Channels beyond the mask always take PLL A.
		mult = 64'(mult_a_reg);
		if (ch < NUM_CHANNELS) begin
			if (source_mask_reg[ch])
				mult = 64'(mult_b_reg);
		end
		prod = 64'(xtal_reg) * mult;
		whole = prod / freq64;
		rem = prod % freq64;
		if (rem == 0) begin
			res.int_mode = 1'b1;
			num = 0;
			den = 1;
		end else begin
			lo_n = 0;
			lo_d = 1;
			hi_n = 1;
			hi_d = 1;
			num = 0;
			den = 1;
			settled = 1'b0;
			while (!settled && lo_d <= WALK_DENOM_MAX && hi_d <= WALK_DENOM_MAX) begin
				med_n = lo_n + hi_n;
				med_d = lo_d + hi_d;
				walk_len++;
				lhs = rem * med_d;
				rhs = freq64 * med_n;
				if (lhs == rhs) begin
					// The fraction is this mediant. Beyond the bound the walk
					// settles on the parent with the larger denominator when
					// that is the right one, otherwise on the left one.
					settled = 1'b1;
					if (med_d <= WALK_DENOM_MAX) begin
						num = med_n;
						den = med_d;
					end else if (hi_d > lo_d) begin
						num = hi_n;
						den = hi_d;
					end else begin
						num = lo_n;
						den = lo_d;
					end
				end else if (lhs > rhs) begin
					lo_n = med_n;
					lo_d = med_d;
				end else begin
					hi_n = med_n;
					hi_d = med_d;
				end
			end
			if (!settled) begin
				if (lo_d > WALK_DENOM_MAX) begin
					num = hi_n;
					den = hi_d;
				end else begin
					num = lo_n;
					den = lo_d;
				end
			end
		end
		q128 = (num << 7) / den;
		// P1 wraps to its field, which covers a small or a zero whole part.
		p1_full = (whole << 7) + q128 - 64'd512;
		p2_full = (num << 7) - den * q128;
		p1 = p1_full[P1_W-1:0];
		p2 = p2_full[P2_W-1:0];
		c = den[P3_W-1:0];
		res.channel = ch;
		res.p1 = p1;
		res.p2 = p2;
		res.p3 = c;
		res.reg_bytes = {c[15:8], c[7:0], 6'b0, p1[17:16], p1[15:8], p1[7:0],
			c[19:16], p2[19:16], p2[15:8], p2[7:0]};
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		$display("mismatch in result %0d, %s: got %h, expected %h",
			results_checked, what, got, want);
	endtask

	// Drives one register write and keeps the bench copy in step with it.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [XTAL_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_XTAL_FREQ:   xtal_reg = data;
			CFG_PLL_A_MULT:  mult_a_reg = data[MULT_W-1:0];
			CFG_PLL_B_MULT:  mult_b_reg = data[MULT_W-1:0];
			CFG_SOURCE_MASK: source_mask_reg = data[MASK_W-1:0];
			default: ;
		endcase
	endtask

	// Offers one item and returns at the edge where its transfer takes place.
	// Valid is left high, so a following item with no gap keeps it high; any
	// gap or the end of a phase lowers it.
	task automatic send_item(input logic [CH_W-1:0] ch, input logic [FREQ_W-1:0] freq);
		divider_params_t want;
		int unsigned walk_len;
		int unsigned gap;
		int unsigned pick;
		want = calc_divider(ch, freq, walk_len);
		// Allow for the longest sender gap, the longest result stall and the
		// block's own cycles for this walk.
		cycle_budget += 85 + 3 * walk_len + 64 + 110 + 16;
		gap = 0;
		if (!steady_flow) begin
			pick = $urandom_range(0, 99);
			if (pick < 55)
				gap = 0;
			else if (pick < 90)
				gap = $urandom_range(1, 3);
			else if (pick < 98)
				gap = $urandom_range(4, 12);
			else
				gap = $urandom_range(20, 60);
		end
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		channel <= ch;
		target_freq <= freq;
		in_valid <= 1'b1;
		expected_params.push_back(want);
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Ends the input stream and waits until every expected result is in, then
	// lets the block settle before anything else happens.
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_params.size() != 0)
			@(posedge clk);
		cycle_budget += SETTLE_CYCLES;
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// With the reset values (25 MHz, both multipliers 36, all channels on
	// PLL A): a zero frequency, exact integers down to a divider of four,
	// the largest whole part, a channel beyond the mask and plain fractions.
	task automatic test_reset_defaults();
		send_item(2'd0, 28'd0);
		send_item(2'd1, 28'd100000000);
		send_item(2'd2, FREQ_MAX);
		send_item(2'd0, 28'd1);
		send_item(2'd3, 28'd7000000);
		send_item(2'd1, 28'd134217729);
		send_item(2'd2, 28'd12345678);
		send_item(2'd0, 28'd3);
		drain_results();
	endtask

	// Different multipliers on the two PLLs, so that the mask decides the
	// result. Upper write data bits are junk and must be ignored.
	task automatic test_pll_selection();
		write_reg(CFG_PLL_A_MULT, 32'hA5A5_A500 | 32'd20);
		write_reg(CFG_PLL_B_MULT, 32'h5A5A_5A00 | 32'd90);
		write_reg(CFG_SOURCE_MASK, 32'hFFFF_FFF8 | 32'b101);
		send_item(2'd0, 28'd33333333);
		send_item(2'd1, 28'd33333333);
		send_item(2'd2, 28'd33333333);
		send_item(2'd3, 28'd33333333);
		drain_results();
		write_reg(CFG_SOURCE_MASK, 32'b010);
		send_item(2'd1, 28'd76543210);
		send_item(2'd3, 28'd76543210);
		drain_results();
	endtask

	// The remainder fraction is chosen to equal a mediant just beyond the
	// denominator bound, once with the larger parent on the right and once on
	// the left. The crystal value is fitted so that xtal * 36 leaves the
	// wanted remainder modulo F31; the second item repeats the first fraction
	// with a larger whole part.
	task automatic test_bound_mediant();
		logic [63:0] numer;
		logic [63:0] fitted;
		int unsigned k;
		int unsigned idx;
		int unsigned lift;
		write_reg(CFG_PLL_A_MULT, 32'(MEDIANT_MULT));
		write_reg(CFG_SOURCE_MASK, 32'b000);
		for (idx = 0; idx < 3; idx++) begin
			numer = (idx == 2) ? FIB_29 : FIB_30;
			lift = (idx == 1) ? 2 : 0;
			fitted = 0;
			for (k = 0; k < MEDIANT_MULT; k++) begin
				if (((64'(k) * FIB_31 + numer) % MEDIANT_MULT) == 0) begin
					fitted = (64'(k) * FIB_31 + numer) / MEDIANT_MULT;
					break;
				end
			end
			fitted = fitted + 64'(lift) * FIB_31;
			write_reg(CFG_XTAL_FREQ, fitted[XTAL_W-1:0]);
			send_item(2'd0, FIB_31[FREQ_W-1:0]);
			drain_results();
		end
	endtask

	// A zero crystal, the widest product and the smallest multiplier with a
	// divider below four.
	task automatic test_config_extremes();
		write_reg(CFG_XTAL_FREQ, 32'd0);
		send_item(2'd1, 28'd12345);
		drain_results();
		write_reg(CFG_XTAL_FREQ, 32'hFFFF_FFFF);
		write_reg(CFG_PLL_A_MULT, 32'd90);
		send_item(2'd0, 28'd1);
		send_item(2'd2, FREQ_MAX);
		send_item(2'd1, 28'h8A5A5A5);
		drain_results();
		write_reg(CFG_XTAL_FREQ, 32'd25000000);
		write_reg(CFG_PLL_A_MULT, 32'd15);
		send_item(2'd0, FREQ_MAX);
		send_item(2'd2, 28'd200000000);
		drain_results();
	endtask

	// Phases of random items, each under a fresh random setting of all four
	// registers. The early phases pin the register extremes; one phase runs
	// with no idling on either side.
	task automatic test_random_phases();
		int phase;
		int n;
		int unsigned pick;
		int unsigned tries;
		int unsigned divisor;
		int unsigned walk_len;
		logic [CH_W-1:0] ch;
		logic [FREQ_W-1:0] freq;
		logic [63:0] prod;
		logic [MULT_W-1:0] mult;
		logic [XTAL_W-1:0] xtal;
		for (phase = 0; phase < 8; phase++) begin
			pick = $urandom_range(0, 99);
			if (phase == 0 || pick >= 95)
				xtal = 32'hFFFF_FFFF;
			else if (pick < 60)
				xtal = $urandom_range(10000000, 40000000);
			else if (pick < 92)
				xtal = $urandom();
			else
				xtal = 32'd0;
			write_reg(CFG_XTAL_FREQ, xtal);
			mult = (phase == 0) ? 7'd90 : (phase == 1) ? 7'd15 : 7'($urandom_range(15, 90));
			write_reg(CFG_PLL_A_MULT, ($urandom() & ~32'h7F) | 32'(mult));
			mult = (phase == 0) ? 7'd15 : (phase == 1) ? 7'd90 : 7'($urandom_range(15, 90));
			write_reg(CFG_PLL_B_MULT, ($urandom() & ~32'h7F) | 32'(mult));
			write_reg(CFG_SOURCE_MASK, ($urandom() & ~32'h7) | 32'($urandom_range(0, 7)));
			steady_flow = (phase == 5);
			for (n = 0; n < 70; n++) begin
				do begin
					ch = ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
					pick = $urandom_range(0, 99);
					freq = 28'($urandom_range(1, FREQ_MAX));
					if (pick < 3) begin
						freq = 28'd0;
					end else if (pick < 13) begin
						// Look for a frequency that divides the product exactly.
						mult = mult_a_reg;
						if (ch < NUM_CHANNELS) begin
							if (source_mask_reg[ch])
								mult = mult_b_reg;
						end
						prod = 64'(xtal_reg) * 64'(mult);
						for (tries = 0; tries < 40; tries++) begin
							divisor = $urandom_range(1, 4000);
							if (prod % divisor == 0 && prod / divisor >= 1 &&
									prod / divisor <= FREQ_MAX) begin
								freq = 28'(prod / divisor);
								break;
							end
						end
					end else if (pick < 22) begin
						freq = 28'($urandom_range(1, 4095));
					end else if (pick < 32) begin
						freq = 28'($urandom_range(150000000, FREQ_MAX));
					end
					void'(calc_divider(ch, freq, walk_len));
				end while (walk_len > WALK_CAP);
				send_item(ch, freq);
			end
			drain_results();
			steady_flow = 1'b0;
		end
	endtask

	// Result side: ready for a random run of cycles, then a stall that is
	// mostly short and now and then long. No stalls while steady_flow is set.
	initial begin : result_backpressure
		int unsigned run_len;
		int unsigned stall_len;
		int unsigned pick;
		out_ready = 1'b0;
		forever begin
			if (steady_flow) begin
				out_ready <= 1'b1;
				@(posedge clk);
			end else begin
				run_len = $urandom_range(1, 20);
				pick = $urandom_range(0, 99);
				if (pick < 60)
					stall_len = $urandom_range(1, 3);
				else if (pick < 95)
					stall_len = $urandom_range(4, 10);
				else
					stall_len = $urandom_range(30, 100);
				out_ready <= 1'b1;
				repeat (run_len) @(posedge clk);
				out_ready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
		end
	end

	// Every result transfer is matched against the oldest expectation. The
	// values sampled here are those from before the edge.
	always @(posedge clk) begin : result_check
		divider_params_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_params.size() == 0) begin
				report_mismatch("result with nothing expected", packed_bytes, 64'd0);
			end else begin
				want = expected_params.pop_front();
				if (out_channel !== want.channel)
					report_mismatch("out_channel", 64'(out_channel), 64'(want.channel));
				if (int_mode !== want.int_mode)
					report_mismatch("int_mode", 64'(int_mode), 64'(want.int_mode));
				if (p1_value !== want.p1)
					report_mismatch("p1_value", 64'(p1_value), 64'(want.p1));
				if (p2_value !== want.p2)
					report_mismatch("p2_value", 64'(p2_value), 64'(want.p2));
				if (p3_value !== want.p3)
					report_mismatch("p3_value", 64'(p3_value), 64'(want.p3));
				if (packed_bytes !== want.reg_bytes)
					report_mismatch("packed_bytes", packed_bytes, want.reg_bytes);
				if (status !== want.status)
					report_mismatch("status", 64'(status), 64'(want.status));
			end
			results_checked++;
		end
	end

	// The limit grows with the work offered: each item adds its worst case,
	// and the whole, settling included, is taken four times over on top of a
	// fixed allowance for reset and register writes.
	initial begin : watchdog
		while (cycles_run <= 4 * cycle_budget + 100000) begin
			@(posedge clk);
			cycles_run++;
		end
		$display("simulation failed");
		$finish;
	end

	initial begin : stimulus_flow
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_XTAL_FREQ;
		cfg_wdata = '0;
		in_valid = 1'b0;
		channel = '0;
		target_freq = '0;
		// The register copy starts at the block's reset values.
		xtal_reg = 32'd25000000;
		mult_a_reg = 7'd36;
		mult_b_reg = 7'd36;
		source_mask_reg = 3'd0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_pll_selection();
		test_bound_mediant();
		test_config_extremes();
		test_random_phases();
		if (expected_params.size() != 0)
			report_mismatch("results never delivered", 64'd0, 64'(expected_params.size()));
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ----- fractional_divider_parameter_calc.f -----
rtl/fdpc_pkg.sv
rtl/fdpc_seq.sv
rtl/fdpc_dp.sv
rtl/fractional_divider_parameter_calc.sv
tb/fractional_divider_parameter_calc_tb.sv
